>>> hdl/assert_macros.svh
// Assertion macros for the spring-mass step block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_RST(label, prop)
`endif
`endif

>>> hdl/dsms_pkg.sv
// Shared types and constants for the spring-mass step block.
package dsms_pkg;
  localparam int MAX_SUBSTEPS_DEF = 7;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [2:0] REG_ANCHOR_X = 3'd0;
  localparam logic [2:0] REG_ANCHOR_Y = 3'd1;
  localparam logic [2:0] REG_REST     = 3'd2;
  localparam logic [2:0] REG_STIFF    = 3'd3;
  localparam logic [2:0] REG_DAMP     = 3'd4;
  localparam logic [2:0] REG_INVM     = 3'd5;
  localparam logic [2:0] REG_DT       = 3'd6;
  localparam logic [2:0] REG_RADIUS   = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SQ, S_SQRT, S_EXT, S_FM, S_FXM, S_DIVX, S_DIVY,
    S_DAMP, S_FORCE, S_HIT1, S_HIT2, S_ACC, S_VEL, S_VADD, S_POS, S_PADD, S_PSUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic sq;
    logic sqrt_start;
    logic ext;
    logic fm;
    logic fxm;
    logic div_start;
    logic div_sel_y;
    logic damp;
    logic fnet;
    logic hit1;
    logic hit2;
    logic acc;
    logic vel;
    logic vadd;
    logic pos;
    logic padd;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic len_zero;
    logic steps_left;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

>>> hdl/damped_spring_mass_step.sv
// Top level of the damped spring-mass frame step.
// Requests are accepted one at a time, only while the sequencer is idle.
// The frame time is dominated by the iterative square root and two divider runs.
// Reset (rst_n low, synchronous) restores registers, ball state and idles the FSM.
module damped_spring_mass_step import dsms_pkg::*; #(
  parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_substeps,
  input  logic               in_grab,
  input  logic signed [31:0] in_pointer_x,
  input  logic signed [31:0] in_pointer_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               out_held
);
  cmd_t  cmd;
  stat_t stat;

  dsms_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
                    .stat, .cmd);
  dsms_datapath #(.MAX_SUBSTEPS(MAX_SUBSTEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .in_substeps, .in_grab, .in_pointer_x, .in_pointer_y,
    .out_pos_x, .out_pos_y, .out_vel_x, .out_vel_y, .out_held);
endmodule

>>> hdl/dsms_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module dsms_sqrt import dsms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] res_r, res_nxt;
  logic [63:0] src_r, src_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [65:0] trial;
  logic [65:0] shifted;

  always_comb begin
    rem_nxt = rem_r; res_nxt = res_r; src_nxt = src_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    shifted = {rem_r, src_r[63:62]};
    trial = {32'd0, res_r, 2'b01};
    if (start) begin
      rem_nxt = '0; res_nxt = '0; src_nxt = val; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      src_nxt = {src_r[61:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = 64'(shifted - trial);
        res_nxt = {res_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        res_nxt = {res_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; res_r <= res_nxt; src_r <= src_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign root = res_r;
endmodule

>>> hdl/dsms_div.sv
// Iterative signed division truncating toward zero, one quotient bit per cycle.
module dsms_div import dsms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [31:0]        den,
  output logic               busy,
  output logic signed [63:0] quo
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    sh = {rem_r, q_r[63]};
    if (start) begin
      q_nxt = num[63] ? 64'(-num) : num;
      rem_nxt = '0; den_nxt = den; neg_nxt = num[63];
      cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {2'b00, den_r}) begin
        rem_nxt = 33'(sh - {2'b00, den_r});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[32:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign quo = neg_r ? 64'(-q_r) : q_r;
endmodule

>>> hdl/dsms_datapath.sv
// Datapath: state, configuration registers and arithmetic for one frame.
module dsms_datapath import dsms_pkg::*; #(
  parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [2:0]         in_substeps,
  input  logic               in_grab,
  input  logic signed [31:0] in_pointer_x,
  input  logic signed [31:0] in_pointer_y,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               out_held
);
  localparam int SW = $clog2(MAX_SUBSTEPS + 1);
  localparam logic [SW-1:0] MAXS = SW'(MAX_SUBSTEPS);

  logic signed [31:0] anc_x_r, anc_y_r;
  logic [30:0] rest_r, stiff_r, damp_r, invm_r, dt_r, rad_r;
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, end_x_r, end_y_r;
  logic signed [31:0] px_r, py_r, dx_r, dy_r, ext_r, fm_r, ax_r, ay_r;
  logic signed [31:0] sfx_r, fx_r, fy_r, t_x_r, t_y_r;
  logic signed [63:0] p_x_r, p_y_r;
  logic [63:0] sq_r;
  logic [63:0] sq_sum;
  logic [31:0] len_r;
  logic        grab_r, held_r, hit_r;
  logic [SW-1:0] steps_r;
  logic [31:0] root;
  logic signed [63:0] quo;
  logic signed [63:0] num;
  logic        sqrt_busy, div_busy;
  logic [32:0] hdx, hdy;
  logic signed [32:0] hdx_s, hdy_s;

  function automatic logic signed [31:0] fshift(input logic signed [63:0] p);
    return sat32(66'(p >>> FRAC_BITS));
  endfunction

  assign sq_sum = p_x_r + p_y_r;
  dsms_sqrt u_sqrt (.clk, .rst_n, .start(cmd.sqrt_start), .val(sq_sum),
                    .busy(sqrt_busy), .root(root));
  assign num = cmd.div_sel_y ? p_y_r : 64'(fm_r) * 64'(dx_r);
  dsms_div u_div (.clk, .rst_n, .start(cmd.div_start), .num(num), .den(len_r),
                  .busy(div_busy), .quo(quo));

  assign stat = '{sqrt_busy: sqrt_busy, div_busy: div_busy,
                  len_zero: (len_r == '0), steps_left: (steps_r != '0)};

  assign hdx_s = 33'(px_r) - 33'(pos_x_r);
  assign hdy_s = 33'(py_r) - 33'(pos_y_r);
  assign hdx = hdx_s[32] ? 33'(-hdx_s) : hdx_s;
  assign hdy = hdy_s[32] ? 33'(-hdy_s) : hdy_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_x_r <= 32'sd26214400; anc_y_r <= 32'sd19660800;
      rest_r <= 31'd5861718; stiff_r <= 31'd6553600; damp_r <= 31'd65536;
      invm_r <= 31'd65536; dt_r <= 31'd1092; rad_r <= 31'd3276800;
      pos_x_r <= 32'sd26214400; pos_y_r <= 32'sd13107200;
      vel_x_r <= '0; vel_y_r <= '0;
      end_x_r <= 32'sd26214400; end_y_r <= 32'sd13107200;
      held_r <= 1'b0; steps_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ANCHOR_X: anc_x_r <= cfg_data;
          REG_ANCHOR_Y: anc_y_r <= cfg_data;
          REG_REST:     rest_r  <= cfg_data[30:0];
          REG_STIFF:    stiff_r <= cfg_data[30:0];
          REG_DAMP:     damp_r  <= cfg_data[30:0];
          REG_INVM:     invm_r  <= cfg_data[30:0];
          REG_DT:       dt_r    <= cfg_data[30:0];
          REG_RADIUS:   rad_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        px_r <= in_pointer_x; py_r <= in_pointer_y; grab_r <= in_grab;
        steps_r <= (32'(in_substeps) > 32'(MAX_SUBSTEPS)) ? MAXS : SW'(in_substeps);
        held_r <= 1'b0;
      end
      if (cmd.diff) begin
        dx_r <= sat32(66'(end_x_r) - 66'(anc_x_r));
        dy_r <= sat32(66'(end_y_r) - 66'(anc_y_r));
      end
      if (cmd.sq) begin
        p_x_r <= 64'(dx_r) * 64'(dx_r); p_y_r <= 64'(dy_r) * 64'(dy_r);
      end
      if (cmd.ext) begin
        len_r <= root;
        ext_r <= sat32(66'($signed({1'b0, root})) - 66'($signed({1'b0, rest_r})));
      end
      if (cmd.fm) p_x_r <= $signed({33'd0, stiff_r}) * ext_r;
      if (cmd.fxm) begin
        fm_r <= sat32(-66'(fshift(p_x_r)));
      end
      if (cmd.div_start && !cmd.div_sel_y) begin
        p_x_r <= 64'(fm_r) * 64'(dx_r); p_y_r <= 64'(fm_r) * 64'(dy_r);
      end
      if (cmd.damp) begin
        p_x_r <= vel_x_r * $signed({33'd0, damp_r});
        p_y_r <= vel_y_r * $signed({33'd0, damp_r});
      end
      if (cmd.div_start && cmd.div_sel_y) sfx_r <= stat.len_zero ? '0 : quo[31:0];
      if (cmd.fnet) begin
        fx_r <= sat32(66'(stat.len_zero ? 32'sd0 : sfx_r) - 66'(fshift(p_x_r)));
        fy_r <= sat32(66'(stat.len_zero ? 32'sd0 : $signed(quo[31:0]))
                      - 66'(fshift(p_y_r)));
      end
      if (cmd.hit1) begin
        hit_r <= grab_r && hdx <= {2'b00, rad_r} && hdy <= {2'b00, rad_r};
        p_x_r <= 64'(hdx[31:0]) * 64'(hdx[31:0]);
        p_y_r <= 64'(hdy[31:0]) * 64'(hdy[31:0]);
        sq_r <= 64'(rad_r) * 64'(rad_r);
      end
      if (cmd.hit2) begin
        if (hit_r && (p_x_r + p_y_r) <= sq_r) begin
          held_r <= 1'b1; pos_x_r <= px_r; pos_y_r <= py_r;
          fx_r <= '0; fy_r <= '0;
          p_x_r <= '0; p_y_r <= '0;
        end else begin
          p_x_r <= fx_r * $signed({33'd0, invm_r});
          p_y_r <= fy_r * $signed({33'd0, invm_r});
        end
      end
      if (cmd.acc) begin
        ax_r <= fshift(p_x_r); ay_r <= fshift(p_y_r);
      end
      if (cmd.vel) begin
        p_x_r <= ax_r * $signed({33'd0, dt_r});
        p_y_r <= ay_r * $signed({33'd0, dt_r});
      end
      if (cmd.vadd) begin
        t_x_r <= sat32(66'(vel_x_r) + 66'(fshift(p_x_r)));
        t_y_r <= sat32(66'(vel_y_r) + 66'(fshift(p_y_r)));
        vel_x_r <= sat32(66'(vel_x_r) + 66'(fshift(p_x_r)));
        vel_y_r <= sat32(66'(vel_y_r) + 66'(fshift(p_y_r)));
      end
      if (cmd.pos) begin
        p_x_r <= t_x_r * $signed({33'd0, dt_r});
        p_y_r <= t_y_r * $signed({33'd0, dt_r});
      end
      if (cmd.padd) begin
        pos_x_r <= sat32(66'(pos_x_r) + 66'(fshift(p_x_r)));
        pos_y_r <= sat32(66'(pos_y_r) + 66'(fshift(p_y_r)));
        end_x_r <= sat32(66'(pos_x_r) + 66'(fshift(p_x_r)));
        end_y_r <= sat32(66'(pos_y_r) + 66'(fshift(p_y_r)));
        steps_r <= steps_r - SW'(1);
      end
    end
  end

  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_vel_x = vel_x_r;
  assign out_vel_y = vel_y_r;
  assign out_held  = held_r;
endmodule

>>> hdl/dsms_ctrl.sv
// Frame sequencer issuing datapath commands.
`include "assert_macros.svh"
module dsms_ctrl import dsms_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin cmd.load = 1'b1; state_nxt = S_DIFF; end
      end
      S_DIFF:  begin cmd.diff = 1'b1; state_nxt = S_SQ; end
      S_SQ:    begin cmd.sq = 1'b1; state_nxt = S_SQRT; end
      S_SQRT:  begin cmd.sqrt_start = 1'b1; state_nxt = S_EXT; end
      S_EXT: begin
        if (!stat.sqrt_busy) begin cmd.ext = 1'b1; state_nxt = S_FM; end
      end
      S_FM:    begin cmd.fm = 1'b1; state_nxt = S_FXM; end
      S_FXM:   begin cmd.fxm = 1'b1; state_nxt = S_DIVX; end
      S_DIVX:  begin cmd.div_start = 1'b1; state_nxt = S_DIVY; end
      S_DIVY: begin
        if (!stat.div_busy) begin
          cmd.div_start = 1'b1; cmd.div_sel_y = 1'b1; state_nxt = S_DAMP;
        end
      end
      S_DAMP: begin
        state_nxt = S_FORCE;
      end
      S_FORCE: begin
        if (!stat.div_busy) begin cmd.damp = 1'b1; state_nxt = S_HIT1; end
      end
      S_HIT1: begin cmd.fnet = 1'b1; state_nxt = S_HIT2; end
      S_HIT2: begin cmd.hit1 = 1'b1; state_nxt = S_ACC; end
      S_ACC: begin cmd.hit2 = 1'b1; state_nxt = S_VEL; end
      S_VEL: begin cmd.acc = 1'b1; state_nxt = S_VADD; end
      S_VADD: begin
        if (stat.steps_left) begin cmd.vel = 1'b1; state_nxt = S_POS; end
        else state_nxt = S_DONE;
      end
      S_POS: begin cmd.vadd = 1'b1; state_nxt = S_PADD; end
      S_PADD: begin cmd.pos = 1'b1; state_nxt = S_PSUM; end
      S_PSUM: begin cmd.padd = 1'b1; state_nxt = S_VADD; end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `ASSERT_RST(a_rst_idle, !rst_n |=> state_r == S_IDLE)
  `ASSERT_CLK(a_one_side, !(in_ready && out_valid))
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_sqrt_idle, cmd.sqrt_start |-> !stat.sqrt_busy)
  `ASSERT_CLK(a_div_idle, cmd.div_start |-> !stat.div_busy)
endmodule
